>>> hw/rtl/ckbi_pkg.sv
// Package for the camera keyframe Bezier interpolator.
// Holds widths, word types, datapath opcodes and the command and status structs.
// No dependencies.
package ckbi_pkg;

  localparam int unsigned MAX_GAP = 64;
  localparam int unsigned GW      = $clog2(MAX_GAP + 1);
  localparam int unsigned TW      = 3 * GW + 7;
  localparam int unsigned NW      = 3 * GW + 7;
  localparam int unsigned QW      = 33;
  localparam int unsigned PW      = QW + NW;
  localparam int unsigned CW      = $clog2(QW + 1);
  localparam int unsigned LW      = 3;

  localparam logic [LW-1:0] VIEW_LANE = LW'(7);
  localparam logic [7:0]    CURVE_END = 8'd127;

  typedef struct packed {
    logic        [31:0] frame_no;
    logic signed [31:0] distance;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] rot_x;
    logic signed [31:0] rot_y;
    logic signed [31:0] rot_z;
    logic        [7:0]  fov_deg;
    logic        [41:0] curves_a;
    logic        [41:0] curves_b;
    logic               last_key;
  } in_t;

  typedef struct packed {
    logic        [31:0] out_frame_no;
    logic               out_is_key;
    logic               gap_error;
    logic signed [31:0] out_distance;
    logic signed [31:0] out_pos_x;
    logic signed [31:0] out_pos_y;
    logic signed [31:0] out_pos_z;
    logic signed [31:0] out_rot_x;
    logic signed [31:0] out_rot_y;
    logic signed [31:0] out_rot_z;
    logic        [23:0] out_fov;
    logic               last;
  } out_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_G2,
    OP_G3,
    OP_DEN,
    OP_TERM1,
    OP_TERM2,
    OP_N1,
    OP_N2,
    OP_MUL,
    OP_DINIT,
    OP_DSTEP,
    OP_WRITE,
    OP_EMIT_FRAME,
    OP_EMIT_KEY
  } op_e;

  typedef struct packed {
    op_e           op;
    logic [LW-1:0] lane;
    logic          phase;
  } cmd_t;

  typedef struct packed {
    logic interp;
    logic j_last;
    logic out_free;
  } sts_t;

endpackage

>>> hw/rtl/ckbi_ctrl.sv
// Sequencer of the keyframe interpolator: walks frames, lanes and divider steps.
// Depends on ckbi_pkg for the command and status structs.
module ckbi_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  ckbi_pkg::sts_t  sts_i,
  output ckbi_pkg::cmd_t  cmd_o
);

  typedef enum logic [14:0] {
    S_IDLE  = 15'b000000000000001,
    S_CHECK = 15'b000000000000010,
    S_G2    = 15'b000000000000100,
    S_G3    = 15'b000000000001000,
    S_DEN   = 15'b000000000010000,
    S_TERM1 = 15'b000000000100000,
    S_TERM2 = 15'b000000001000000,
    S_N1    = 15'b000000010000000,
    S_N2    = 15'b000000100000000,
    S_MUL   = 15'b000001000000000,
    S_DINIT = 15'b000010000000000,
    S_DSTEP = 15'b000100000000000,
    S_WRITE = 15'b001000000000000,
    S_EMIT  = 15'b010000000000000,
    S_KEY   = 15'b100000000000000
  } state_e;

  state_e                      state_q, state_d;
  logic [ckbi_pkg::LW-1:0]     lane_q, lane_d;
  logic                        phase_q, phase_d;
  logic [ckbi_pkg::CW-1:0]     cnt_q, cnt_d;

  always_comb begin
    state_d     = state_q;
    lane_d      = lane_q;
    phase_d     = phase_q;
    cnt_d       = cnt_q;
    in_ready_o  = 1'b0;
    cmd_o.op    = ckbi_pkg::OP_NONE;
    cmd_o.lane  = lane_q;
    cmd_o.phase = phase_q;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = ckbi_pkg::OP_LOAD;
          state_d  = S_CHECK;
        end
      end
      S_CHECK: begin
        lane_d  = '0;
        phase_d = 1'b0;
        state_d = sts_i.interp ? S_G2 : S_KEY;
      end
      S_G2: begin
        cmd_o.op = ckbi_pkg::OP_G2;
        state_d  = S_G3;
      end
      S_G3: begin
        cmd_o.op = ckbi_pkg::OP_G3;
        state_d  = S_DEN;
      end
      S_DEN: begin
        cmd_o.op = ckbi_pkg::OP_DEN;
        state_d  = S_TERM1;
      end
      S_TERM1: begin
        cmd_o.op = ckbi_pkg::OP_TERM1;
        state_d  = S_TERM2;
      end
      S_TERM2: begin
        cmd_o.op = ckbi_pkg::OP_TERM2;
        state_d  = S_N1;
      end
      S_N1: begin
        cmd_o.op = ckbi_pkg::OP_N1;
        state_d  = S_N2;
      end
      S_N2: begin
        cmd_o.op = ckbi_pkg::OP_N2;
        state_d  = (lane_q == ckbi_pkg::VIEW_LANE) ? S_DINIT : S_MUL;
      end
      S_MUL: begin
        cmd_o.op = ckbi_pkg::OP_MUL;
        state_d  = S_DINIT;
      end
      S_DINIT: begin
        cmd_o.op = ckbi_pkg::OP_DINIT;
        cnt_d    = '0;
        state_d  = S_DSTEP;
      end
      S_DSTEP: begin
        cmd_o.op = ckbi_pkg::OP_DSTEP;
        cnt_d    = cnt_q + ckbi_pkg::CW'(1);
        if (cnt_q == ckbi_pkg::CW'(ckbi_pkg::QW - 1)) begin
          state_d = S_WRITE;
        end
      end
      S_WRITE: begin
        cmd_o.op = ckbi_pkg::OP_WRITE;
        if (lane_q != ckbi_pkg::VIEW_LANE) begin
          lane_d  = lane_q + ckbi_pkg::LW'(1);
          state_d = S_N1;
        end else if (!phase_q) begin
          phase_d = 1'b1;
          state_d = S_MUL;
        end else begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.op = ckbi_pkg::OP_EMIT_FRAME;
          lane_d   = '0;
          phase_d  = 1'b0;
          state_d  = sts_i.j_last ? S_KEY : S_TERM1;
        end
      end
      S_KEY: begin
        if (sts_i.out_free) begin
          cmd_o.op = ckbi_pkg::OP_EMIT_KEY;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      lane_q  <= '0;
      phase_q <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      lane_q  <= lane_d;
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

>>> hw/rtl/ckbi_dp.sv
// Datapath of the keyframe interpolator: stored key, curve terms, multiplier,
// radix-2 divider and output register. Depends on ckbi_pkg.
module ckbi_dp (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ckbi_pkg::in_t   in_data_i,
  input  ckbi_pkg::cmd_t  cmd_i,
  output ckbi_pkg::sts_t  sts_o,
  input  logic            out_ready_i,
  output logic            out_valid_o,
  output ckbi_pkg::out_t  out_data_o
);

  localparam int unsigned GW = ckbi_pkg::GW;
  localparam int unsigned TW = ckbi_pkg::TW;
  localparam int unsigned NW = ckbi_pkg::NW;
  localparam int unsigned QW = ckbi_pkg::QW;
  localparam int unsigned PW = ckbi_pkg::PW;

  ckbi_pkg::in_t             key_q;
  logic                      have_prev_q;
  logic [31:0]               prev_frame_q;
  logic signed [31:0]        prev_val_q [7];
  logic [7:0]                prev_view_q;
  logic                      err_q, interp_q;
  logic [GW-1:0]             g_q, j_q;
  logic [2*GW-1:0]           g2_q, rr_q, rj_q, jj_q;
  logic [3*GW-1:0]           g3_q;
  logic [NW-1:0]             den_q, n_q, rem_q, dsor_q;
  logic [TW-1:0]             a_q, b_q, c_q;
  logic signed [PW-1:0]      prod_q;
  logic [QW-1:0]             dq_q;
  logic                      neg_q;
  logic [6:0]                w_q;
  logic signed [31:0]        res_q [7];
  logic [23:0]               view_res_q;
  ckbi_pkg::out_t            out_q;
  logic                      out_valid_q;

  logic signed [31:0]        key_v [7];
  logic [31:0]               diff;
  logic                      gap_ok;
  logic [GW-1:0]             r;
  logic [6:0]                c1, c2;
  logic signed [32:0]        dval;
  logic signed [QW+NW:0]     full_prod;
  logic signed [8:0]         vdiff;
  logic signed [16:0]        vprod;
  logic [PW-1:0]             mag, prod_abs, dividend, bias;
  logic [NW-1:0]             dsor_sel;
  logic                      neg_sel;
  logic [NW:0]               trial;
  logic                      ge;
  logic [QW-1:0]             q_s;

  assign key_v[0] = key_q.distance;
  assign key_v[1] = key_q.pos_x;
  assign key_v[2] = key_q.pos_y;
  assign key_v[3] = key_q.pos_z;
  assign key_v[4] = key_q.rot_x;
  assign key_v[5] = key_q.rot_y;
  assign key_v[6] = key_q.rot_z;

  assign diff   = in_data_i.frame_no - prev_frame_q;
  assign gap_ok = have_prev_q && (in_data_i.frame_no > prev_frame_q) &&
                  (diff <= 32'(ckbi_pkg::MAX_GAP));
  assign r      = g_q - j_q;

  always_comb begin
    case (cmd_i.lane)
      3'd0:    begin c1 = key_q.curves_b[14+:7]; c2 = key_q.curves_b[21+:7]; end
      3'd1:    begin c1 = key_q.curves_a[0+:7];  c2 = key_q.curves_a[7+:7];  end
      3'd2:    begin c1 = key_q.curves_a[14+:7]; c2 = key_q.curves_a[21+:7]; end
      3'd3:    begin c1 = key_q.curves_a[28+:7]; c2 = key_q.curves_a[35+:7]; end
      3'd7:    begin c1 = key_q.curves_b[28+:7]; c2 = key_q.curves_b[35+:7]; end
      default: begin c1 = key_q.curves_b[0+:7];  c2 = key_q.curves_b[7+:7];  end
    endcase
  end

  always_comb begin
    dval      = '0;
    if (cmd_i.lane != ckbi_pkg::VIEW_LANE) begin
      dval = {key_v[cmd_i.lane][31], key_v[cmd_i.lane]} -
             {prev_val_q[cmd_i.lane][31], prev_val_q[cmd_i.lane]};
    end
    full_prod = dval * $signed({1'b0, n_q});
    vdiff     = $signed({1'b0, key_q.fov_deg}) - $signed({1'b0, prev_view_q});
    vprod     = vdiff * $signed({2'b00, w_q});
    prod_abs  = prod_q[PW-1] ? PW'(-prod_q) : PW'(prod_q);
    if (cmd_i.lane != ckbi_pkg::VIEW_LANE) begin
      mag      = prod_abs;
      dsor_sel = den_q;
      neg_sel  = prod_q[PW-1];
    end else if (!cmd_i.phase) begin
      mag      = PW'(n_q);
      dsor_sel = NW'(g3_q);
      neg_sel  = 1'b0;
    end else begin
      mag      = prod_abs;
      dsor_sel = NW'(ckbi_pkg::CURVE_END);
      neg_sel  = prod_q[PW-1];
    end
    bias     = (cmd_i.lane == ckbi_pkg::VIEW_LANE && !cmd_i.phase) ? '0
             : PW'(dsor_sel >> 1);
    dividend = mag + bias;
    trial    = {rem_q, dq_q[QW-1]};
    ge       = trial >= {1'b0, dsor_q};
    q_s      = neg_q ? QW'(-dq_q) : dq_q;
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      ckbi_pkg::OP_LOAD: begin
        key_q <= in_data_i;
        g_q   <= diff[GW-1:0];
        j_q   <= GW'(1);
      end
      ckbi_pkg::OP_G2:    g2_q  <= (2*GW)'(g_q) * (2*GW)'(g_q);
      ckbi_pkg::OP_G3:    g3_q  <= (3*GW)'(g2_q) * (3*GW)'(g_q);
      ckbi_pkg::OP_DEN:   den_q <= NW'(g3_q) * NW'(ckbi_pkg::CURVE_END);
      ckbi_pkg::OP_TERM1: begin
        rr_q <= (2*GW)'(r) * (2*GW)'(r);
        rj_q <= (2*GW)'(r) * (2*GW)'(j_q);
        jj_q <= (2*GW)'(j_q) * (2*GW)'(j_q);
      end
      ckbi_pkg::OP_TERM2: begin
        a_q <= TW'(rr_q) * TW'(j_q) * TW'(2'd3);
        b_q <= TW'(rj_q) * TW'(j_q) * TW'(2'd3);
        c_q <= TW'(jj_q) * TW'(j_q) * TW'(ckbi_pkg::CURVE_END);
      end
      ckbi_pkg::OP_N1:    n_q <= NW'(a_q) * NW'(c1) + NW'(c_q);
      ckbi_pkg::OP_N2:    n_q <= n_q + NW'(b_q) * NW'(c2);
      ckbi_pkg::OP_MUL: begin
        if (cmd_i.lane != ckbi_pkg::VIEW_LANE) begin
          prod_q <= full_prod[PW-1:0];
        end else begin
          prod_q <= PW'(vprod) <<< 16;
        end
      end
      ckbi_pkg::OP_DINIT: begin
        rem_q  <= dividend[PW-1:QW];
        dq_q   <= dividend[QW-1:0];
        dsor_q <= dsor_sel;
        neg_q  <= neg_sel;
      end
      ckbi_pkg::OP_DSTEP: begin
        rem_q <= ge ? NW'(trial - {1'b0, dsor_q}) : trial[NW-1:0];
        dq_q  <= {dq_q[QW-2:0], ge};
      end
      ckbi_pkg::OP_WRITE: begin
        if (cmd_i.lane != ckbi_pkg::VIEW_LANE) begin
          res_q[cmd_i.lane] <= prev_val_q[cmd_i.lane] + $signed(q_s[31:0]);
        end else if (!cmd_i.phase) begin
          w_q <= dq_q[6:0];
        end else begin
          view_res_q <= {prev_view_q, 16'd0} + q_s[23:0];
        end
      end
      ckbi_pkg::OP_EMIT_FRAME: j_q <= j_q + GW'(1);
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_prev_q  <= 1'b0;
      prev_frame_q <= '0;
      prev_view_q  <= '0;
      err_q        <= 1'b0;
      interp_q     <= 1'b0;
      out_valid_q  <= 1'b0;
      for (int i = 0; i < 7; i++) prev_val_q[i] <= '0;
    end else begin
      if (cmd_i.op == ckbi_pkg::OP_EMIT_FRAME || cmd_i.op == ckbi_pkg::OP_EMIT_KEY) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (cmd_i.op)
        ckbi_pkg::OP_LOAD: begin
          err_q    <= have_prev_q && !gap_ok;
          interp_q <= gap_ok && (diff != 32'd1);
        end
        ckbi_pkg::OP_EMIT_KEY: begin
          if (key_q.last_key) begin
            have_prev_q  <= 1'b0;
            prev_frame_q <= '0;
            prev_view_q  <= '0;
            for (int i = 0; i < 7; i++) prev_val_q[i] <= '0;
          end else begin
            have_prev_q  <= 1'b1;
            prev_frame_q <= key_q.frame_no;
            prev_view_q  <= key_q.fov_deg;
            for (int i = 0; i < 7; i++) prev_val_q[i] <= key_v[i];
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == ckbi_pkg::OP_EMIT_FRAME) begin
      out_q.out_frame_no   <= prev_frame_q + 32'(j_q);
      out_q.out_is_key     <= 1'b0;
      out_q.gap_error      <= 1'b0;
      out_q.out_distance   <= res_q[0];
      out_q.out_pos_x      <= res_q[1];
      out_q.out_pos_y      <= res_q[2];
      out_q.out_pos_z      <= res_q[3];
      out_q.out_rot_x      <= res_q[4];
      out_q.out_rot_y      <= res_q[5];
      out_q.out_rot_z      <= res_q[6];
      out_q.out_fov        <= view_res_q;
      out_q.last           <= 1'b0;
    end else if (cmd_i.op == ckbi_pkg::OP_EMIT_KEY) begin
      out_q.out_frame_no   <= key_q.frame_no;
      out_q.out_is_key     <= 1'b1;
      out_q.gap_error      <= err_q;
      out_q.out_distance   <= key_q.distance;
      out_q.out_pos_x      <= key_q.pos_x;
      out_q.out_pos_y      <= key_q.pos_y;
      out_q.out_pos_z      <= key_q.pos_z;
      out_q.out_rot_x      <= key_q.rot_x;
      out_q.out_rot_y      <= key_q.rot_y;
      out_q.out_rot_z      <= key_q.rot_z;
      out_q.out_fov        <= {key_q.fov_deg, 16'd0};
      out_q.last           <= 1'b1;
    end
  end

  assign sts_o.interp   = interp_q;
  assign sts_o.j_last   = (j_q + GW'(1)) == g_q;
  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign out_data_o     = out_q;

endmodule

>>> hw/rtl/camera_keyframe_bezier_interp_top.sv
// Camera keyframe interpolator with cubic Bezier easing, top level.
// Depends on ckbi_pkg, ckbi_ctrl and ckbi_dp.
//
// One keyframe word is taken at a time. A key with a gap g of two to 64 frames to
// the stored key yields g-1 in-between frame words and then the key word; any
// other key yields only the key word. For every in-between frame, each of the
// seven value lanes runs one multiply and one radix-2 division on the shared
// divider, and the view angle takes two such divisions. A key alone goes from
// acceptance through the check state to its word; a key with in-between frames
// first computes the gap square, cube and denominator. The next frame is computed
// while the previous result word waits in the output register.
module camera_keyframe_bezier_interp_top (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  ckbi_pkg::in_t   in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output ckbi_pkg::out_t  out_data_o
);

  ckbi_pkg::cmd_t cmd;
  ckbi_pkg::sts_t sts;

  ckbi_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ckbi_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("Input accepted while a word was still in work.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.last |-> out_data_o.out_is_key)
    else $error("Final word of a key is not the key.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.gap_error |-> out_data_o.out_is_key)
    else $error("Gap error flagged on an in-between frame.");
`endif

endmodule
